/* hdl/clc_pkg.sv */
`default_nettype none
package clc_pkg;

   // Input word and its decimal form.
   localparam int NUM_BITS   = 54;
   localparam int REQ_DATA_W = 56;
   localparam int NUM_DIGITS = 17;
   localparam int BCD_W      = NUM_DIGITS * 4;

   // Step counter covers the longer of the two passes.
   localparam int CNT_W = 6;
   localparam int POS_W = 5;

   // Result fields.
   localparam int CLASS_W    = 2;
   localparam int COUNT_W    = 5;
   localparam int RSP_DATA_W = 8;
   localparam int MAX_DIGITS = 17;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_INVALID = 2'd0,
      CLASS_PFX_3X  = 2'd1,
      CLASS_PFX_5X  = 2'd2,
      CLASS_PFX_4X  = 2'd3
   } card_class_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             conv_step;
      logic             scan_step;
      logic             emit;
      logic [POS_W-1:0] pos;
   } cmd_type;

endpackage
`default_nettype wire

/* hdl/clc_ctrl.sv */
`default_nettype none
module clc_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output clc_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CONV   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [clc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.pos       = cnt_ff[clc_pkg::POS_W-1:0];
      req_tready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (cnt_ff == clc_pkg::CNT_W'(clc_pkg::NUM_BITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (cnt_ff == clc_pkg::CNT_W'(clc_pkg::NUM_DIGITS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CONV))
      else $error("accepted item did not start conversion");

   a_conv_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (cnt_ff < clc_pkg::CNT_W'(clc_pkg::NUM_BITS)))
      else $error("conversion step count out of range");

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_scan_follows_conv: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CONV) && (cnt_ff == clc_pkg::CNT_W'(clc_pkg::NUM_BITS - 1)))
      |=> (state_ff == ST_SCAN) && (cnt_ff == '0))
      else $error("digit scan did not follow conversion");

endmodule
`default_nettype wire

/* hdl/clc_dp.sv */
`default_nettype none
module clc_dp (
   input  wire logic                             clock,
   input  wire clc_pkg::cmd_type                 cmd,
   input  wire logic [clc_pkg::NUM_BITS-1:0]     card_number,
   output logic [clc_pkg::CLASS_W-1:0]           card_class,
   output logic [clc_pkg::COUNT_W-1:0]           digit_count,
   output logic                                  luhn_pass
);

   logic [clc_pkg::NUM_BITS-1:0] bin_ff, bin_in;
   logic [clc_pkg::BCD_W-1:0]    bcd_ff, bcd_in;
   logic [3:0]                   sum_ff, sum_in;
   logic [clc_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [3:0]                   hi_ff, hi_in;
   logic [3:0]                   lo_ff, lo_in;
   logic [3:0]                   prev_ff, prev_in;

   logic [clc_pkg::CLASS_W-1:0]  class_ff, class_in;
   logic [clc_pkg::COUNT_W-1:0]  dcount_ff, dcount_in;
   logic                         pass_ff, pass_in;

   logic [clc_pkg::BCD_W-1:0]    bcd_adj;
   logic [3:0]                   digit;
   logic [3:0]                   contrib;
   logic [4:0]                   sum_raw;
   logic                         count_ok;
   logic                         luhn_ok;

   // Shift-and-add-3 adjust: every digit at five or more gets three added.
   always_comb begin
      bcd_adj = bcd_ff;
      for (int i = 0; i < clc_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end
      end
   end

   // Luhn contribution of the units digit of the shifting register.
   always_comb begin
      digit = bcd_ff[3:0];
      if (!cmd.pos[0]) begin
         contrib = digit;
      end else if (digit >= 4'd5) begin
         contrib = 4'((5'(digit) << 1) - 5'd9);
      end else begin
         contrib = 4'(digit << 1);
      end
      sum_raw = 5'(sum_ff) + 5'(contrib);
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      prev_in  = prev_ff;
      if (cmd.load) begin
         bin_in   = card_number;
         bcd_in   = '0;
         sum_in   = '0;
         count_in = '0;
         hi_in    = '0;
         lo_in    = '0;
         prev_in  = '0;
      end else if (cmd.conv_step) begin
         bcd_in = {bcd_adj[clc_pkg::BCD_W-2:0], bin_ff[clc_pkg::NUM_BITS-1]};
         bin_in = {bin_ff[clc_pkg::NUM_BITS-2:0], 1'b0};
      end else if (cmd.scan_step) begin
         bcd_in  = {4'd0, bcd_ff[clc_pkg::BCD_W-1:4]};
         sum_in  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
         prev_in = digit;
         if (digit != 4'd0) begin
            count_in = clc_pkg::COUNT_W'(cmd.pos) + 1'b1;
            hi_in    = digit;
            lo_in    = prev_ff;
         end
      end
   end

   // Classification from the finished digit scan.
   always_comb begin
      luhn_ok  = (sum_ff == 4'd0);
      count_ok = (count_ff == 5'd13) || (count_ff == 5'd15) || (count_ff == 5'd16);
      class_in = class_ff;
      dcount_in = dcount_ff;
      pass_in  = pass_ff;
      if (cmd.emit) begin
         pass_in = luhn_ok;
         if (count_ff > clc_pkg::COUNT_W'(clc_pkg::MAX_DIGITS)) begin
            dcount_in = clc_pkg::COUNT_W'(clc_pkg::MAX_DIGITS);
         end else begin
            dcount_in = count_ff;
         end
         class_in = clc_pkg::CLASS_INVALID;
         if (count_ok && luhn_ok) begin
            priority if (hi_ff == 4'd5 && lo_ff > 4'd0 && lo_ff < 4'd6) begin
               class_in = clc_pkg::CLASS_PFX_5X;
            end else if (hi_ff == 4'd3 && (lo_ff == 4'd4 || lo_ff == 4'd7)) begin
               class_in = clc_pkg::CLASS_PFX_3X;
            end else if (hi_ff == 4'd4) begin
               class_in = clc_pkg::CLASS_PFX_4X;
            end else begin
               class_in = clc_pkg::CLASS_INVALID;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      sum_ff    <= sum_in;
      count_ff  <= count_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      prev_ff   <= prev_in;
      class_ff  <= class_in;
      dcount_ff <= dcount_in;
      pass_ff   <= pass_in;
   end

   assign card_class  = class_ff;
   assign digit_count = dcount_ff;
   assign luhn_pass   = pass_ff;

endmodule
`default_nettype wire

/* hdl/card_number_luhn_classify.sv */
// Card number checksum and prefix classifier.
//
// The req_ channel carries one item per card number: the number as an
// unsigned binary integer in req_tdata[53:0]; the top two bits are ignored.
// The rsp_ channel returns exactly one item per accepted input, in order:
// the class code, the decimal digit count and the Luhn pass flag.
//
// An item is worked on alone. The binary word is converted to 17 decimal
// digits by shift-and-add-3, one input bit per cycle, then the digits are
// scanned from the units position, one per cycle, accumulating the Luhn
// sum, the digit count and the two leading digits. A finish state then
// loads the result register that drives rsp_tvalid, and the controller
// returns to idle, so a new item is taken only once the last one is
// through.
//
// The result sits in an output register, so the next item is accepted while
// a finished result still waits. If the receiver holds rsp_tready low, the
// following result waits in the controller after its scan until the register
// frees up, and no further item is accepted meanwhile.
// Synchronous reset returns the controller to idle and drops rsp_tvalid.
`default_nettype none
module card_number_luhn_classify (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [clc_pkg::REQ_DATA_W-1:0]     req_tdata,  // card_number[53:0]
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [clc_pkg::RSP_DATA_W-1:0]          rsp_tdata   // card_class[1:0],
                                                               // digit_count[6:2],
                                                               // luhn_pass[7]
);

   // Command bundle from the sequencer to the datapath.
   clc_pkg::cmd_type                 cmd;
   logic [clc_pkg::CLASS_W-1:0]      card_class;
   logic [clc_pkg::COUNT_W-1:0]      digit_count;
   logic                             luhn_pass;

   clc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   clc_dp u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .card_number (req_tdata[clc_pkg::NUM_BITS-1:0]),
      .card_class  (card_class),
      .digit_count (digit_count),
      .luhn_pass   (luhn_pass)
   );

   // Result fields packed from the lowest bit up.
   assign rsp_tdata = {luhn_pass, digit_count, card_class};

endmodule
`default_nettype wire

/* bench/tb_card_number_luhn_classify.sv */
`timescale 1ns / 1ps

// Testbench for the card number checksum and prefix classifier.
//
// Every item sent on the req_ channel is a card number. At the moment an item
// is accepted, the bench works out the expected class, digit count and Luhn
// flag and appends them to a queue. A checker compares every item taken from
// the rsp_ channel, field by field, with the oldest entry of that queue.
//
// Timing rule: inputs change only by nonblocking assignments right after a
// rising edge. DUT outputs are sampled at the falling edge, where they are
// stable. A handshake seen at a falling edge completes at the next rising
// edge.
module tb_card_number_luhn_classify;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 10;
   // The longest correct quiet stretch is the long receiver hold-off plus
   // one item's latency. The limit is several times that.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_REPORTS = 50;
   localparam longint unsigned CARD_MAX = (64'd1 << clc_pkg::NUM_BITS) - 64'd1;

   typedef struct packed {
      clc_pkg::card_class_type           card_class;
      logic [clc_pkg::COUNT_W-1:0]       digit_count;
      logic                              luhn_pass;
   } card_verdict_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [clc_pkg::REQ_DATA_W-1:0]   req_tdata = '0;   // card_number[53:0], two unused bits above
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [clc_pkg::RSP_DATA_W-1:0]   rsp_tdata;        // card_class[1:0], digit_count[6:2],
                                                       // luhn_pass[7]

   // Verdicts of accepted card numbers whose result has not come back yet.
   card_verdict_type verdict_queue[$];
   int unsigned   error_count = 0;
   int unsigned   quiet_cycles = 0;

   // Idling controls. The sender rate is used only by the stimulus process.
   // The receiver controls are written with nonblocking assignments, so that
   // the receiver process reads them without a race.
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_len = 0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int unsigned hold_left = 0;

   card_number_luhn_classify dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Walks the decimal digits from the units position. It returns the Luhn
   // sum and the true digit count, which is zero for zero.
   function automatic void luhn_digits(input logic [clc_pkg::NUM_BITS-1:0] num,
                                       output int unsigned sum,
                                       output int unsigned ndigits);
      longint unsigned rest;
      int unsigned     digit;
      int unsigned     doubled;
      rest = num;
      sum = 0;
      ndigits = 0;
      while (rest != 0) begin
         digit = int'(rest % 64'd10);
         rest = rest / 64'd10;
         if (ndigits % 2 == 0) begin
            sum += digit;
         end else begin
            doubled = digit * 2;
            sum += doubled % 10 + doubled / 10;
         end
         ndigits++;
      end
   endfunction

   // Expected verdict for one card number.
   function automatic card_verdict_type classify_card(
      input logic [clc_pkg::NUM_BITS-1:0] num);
      card_verdict_type verdict;
      int unsigned     sum;
      int unsigned     ndigits;
      longint unsigned lead;
      int unsigned     hi;
      int unsigned     lo;
      luhn_digits(num, sum, ndigits);
      verdict.luhn_pass = (sum % 10 == 0);
      verdict.card_class = clc_pkg::CLASS_INVALID;
      if ((ndigits == 13 || ndigits == 15 || ndigits == 16) && verdict.luhn_pass) begin
         lead = num;
         repeat (ndigits - 2) lead = lead / 64'd10;
         hi = int'(lead / 64'd10);
         lo = int'(lead % 64'd10);
         if (hi == 5 && lo >= 1 && lo <= 5) begin
            verdict.card_class = clc_pkg::CLASS_PFX_5X;
         end else if (hi == 3 && (lo == 4 || lo == 7)) begin
            verdict.card_class = clc_pkg::CLASS_PFX_3X;
         end else if (hi == 4) begin
            verdict.card_class = clc_pkg::CLASS_PFX_4X;
         end
      end
      if (ndigits > clc_pkg::MAX_DIGITS) begin
         ndigits = clc_pkg::MAX_DIGITS;
      end
      verdict.digit_count = clc_pkg::COUNT_W'(ndigits);
      return verdict;
   endfunction

   // Builds a number of ndigits digits (three or more) that starts with the
   // two digits of prefix. The check digit makes the Luhn sum a multiple of
   // ten, or is pushed off by a nonzero amount when luhn_ok is clear.
   function automatic logic [clc_pkg::NUM_BITS-1:0] make_card(
      input int unsigned ndigits,
      input int unsigned prefix,
      input bit luhn_ok);
      longint unsigned body;
      int unsigned     sum;
      int unsigned     cnt;
      int unsigned     check;
      body = prefix;
      repeat (ndigits - 3) body = body * 64'd10 + $urandom_range(9);
      luhn_digits(clc_pkg::NUM_BITS'(body * 64'd10), sum, cnt);
      check = (10 - sum % 10) % 10;
      if (!luhn_ok) begin
         check = (check + $urandom_range(1, 9)) % 10;
      end
      return clc_pkg::NUM_BITS'(body * 64'd10 + check);
   endfunction

   function automatic logic [clc_pkg::NUM_BITS-1:0] random_word();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[clc_pkg::NUM_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_REPORTS) begin
         $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      end
      error_count++;
   endtask

   // Sends one card number and returns at the rising edge that accepts it.
   // The valid line stays high afterwards. The next call either replaces
   // the data in the same step or lowers valid for a gap.
   task automatic send_card(input logic [clc_pkg::NUM_BITS-1:0] num);
      logic [clc_pkg::REQ_DATA_W-clc_pkg::NUM_BITS-1:0] pad;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      // The two bits above the card number are ignored by the block, so they
      // carry random values.
      pad = (clc_pkg::REQ_DATA_W - clc_pkg::NUM_BITS)'($urandom);
      req_tvalid <= 1'b1;
      req_tdata <= {pad, num};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      verdict_queue.push_back(classify_card(num));
   endtask

   // Receiver. It stalls at random and, when it is asked, holds off for a
   // counted stretch of cycles.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result checker. A handshake seen here completes at the next rising edge.
   always @(negedge clock) begin
      card_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected result, data", int'(rsp_tdata), -1);
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_tdata[1:0] !== want.card_class) begin
               report_mismatch("card_class", int'(rsp_tdata[1:0]), int'(want.card_class));
            end
            if (rsp_tdata[6:2] !== want.digit_count) begin
               report_mismatch("digit_count", int'(rsp_tdata[6:2]), int'(want.digit_count));
            end
            if (rsp_tdata[7] !== want.luhn_pass) begin
               report_mismatch("luhn_pass", int'(rsp_tdata[7]), int'(want.luhn_pass));
            end
         end
      end
   end

   // Watchdog. It counts cycles in which neither channel moves an item.
   always @(negedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Extremes of the field and each special case: zero, the largest word,
   // all three accepted lengths with known prefixes of every class, unknown prefixes,
   // Luhn failures, wrong digit counts and 17-digit numbers.
   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      send_card('0);
      send_card(clc_pkg::NUM_BITS'(CARD_MAX));
      send_card(clc_pkg::NUM_BITS'(1));
      send_card(clc_pkg::NUM_BITS'(64'd9));
      send_card(make_card(15, 34, 1'b1));
      send_card(make_card(15, 37, 1'b1));
      send_card(make_card(16, 51, 1'b1));
      send_card(make_card(16, 53, 1'b1));
      send_card(make_card(16, 55, 1'b1));
      send_card(make_card(13, 40, 1'b1));
      send_card(make_card(16, 49, 1'b1));
      send_card(make_card(15, 45, 1'b1));
      // Unknown prefixes next to the known ones.
      send_card(make_card(16, 50, 1'b1));
      send_card(make_card(16, 56, 1'b1));
      send_card(make_card(15, 36, 1'b1));
      send_card(make_card(13, 39, 1'b1));
      // A good prefix with a broken check digit.
      send_card(make_card(16, 51, 1'b0));
      send_card(make_card(13, 42, 1'b0));
      // Lengths that are not classified; all but the last pass the Luhn check.
      send_card(make_card(14, 44, 1'b1));
      send_card(make_card(12, 41, 1'b1));
      send_card(make_card(17, 17, 1'b1));
      send_card(make_card(17, 10, 1'b0));
      // Smallest and largest 16-digit numbers.
      send_card(clc_pkg::NUM_BITS'(64'd1000000000000000));
      send_card(clc_pkg::NUM_BITS'(64'd9999999999999999));
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering items, so the output register and the controller fill up and
   // the block has to stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      hold_len <= HOLD_OFF_CYCLES;
      hold_toggle <= ~hold_toggle;
      repeat (12) send_card(make_card(16, 40 + $urandom_range(9), 1'b1));
   endtask

   // Mostly well-formed numbers with random content, mixed with broken ones,
   // numbers of three to seventeen digits and raw words of random width.
   task automatic test_random(input int unsigned items, input int unsigned idle_pct,
                              input int unsigned stall_pct);
      int unsigned pick;
      int unsigned ndigits;
      int unsigned prefix;
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
      repeat (items) begin
         pick = $urandom_range(99);
         case ($urandom_range(2))
            0: ndigits = 13;
            1: ndigits = 15;
            default: ndigits = 16;
         endcase
         case ($urandom_range(9))
            0, 1: prefix = $urandom_range(0, 1) ? 34 : 37;
            2, 3, 4: prefix = $urandom_range(51, 55);
            5, 6: prefix = $urandom_range(40, 49);
            default: prefix = $urandom_range(10, 99);
         endcase
         if (pick < 55) begin
            send_card(make_card(ndigits, prefix, 1'b1));
         end else if (pick < 70) begin
            send_card(make_card(ndigits, prefix, 1'b0));
         end else if (pick < 85) begin
            ndigits = $urandom_range(3, 17);
            // Seventeen-digit numbers must stay below the top of the word.
            prefix = (ndigits == 17) ? $urandom_range(10, 17) : $urandom_range(10, 99);
            send_card(make_card(ndigits, prefix, 1'($urandom_range(0, 1))));
         end else begin
            send_card(random_word() >> $urandom_range(clc_pkg::NUM_BITS - 1));
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random(220, 0, 0);
      test_random(220, 47, 0);
      test_random(220, 0, 47);
      test_random(220, 35, 35);

      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
